### sv/bsp_pkg.sv
// bsp_pkg: shared types and constants for the sorted table with probing search.
// No dependencies; used by bsp_probe and binary_search_with_probe_trace.
`timescale 1ns / 1ps

package bsp_pkg;

  // Default number of table entries
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // Field widths fixed by the interface
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 11;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Index reported when the key is absent
  localparam logic signed [INDEX_W-1:0] NOT_FOUND = -11'sd1;

  // Outcome of one probe compare
  typedef struct packed {
    logic hit;   // probed entry equals the key
    logic done;  // search ends at this probe
  } probe_stat_t;

endpackage

### sv/binary_search_with_probe_trace.sv
// binary_search_with_probe_trace: sorted table in a synchronous RAM with a
// probing binary search. Depends on bsp_pkg and bsp_probe.
`timescale 1ns / 1ps

// Append, clear and unknown requests each give one result. Clear, unknown and an
// append to an empty or full table give it straight from idle; any other append
// first does a RAM read of the last entry, then the order check and write.
// A search of n entries gives one result per probe, with p <= floor(log2 n) + 1
// probes; each probe is one RAM read and compare through the table RAM's
// single read port. busy_o is low in the
// cycle a request can be taken. Each result is on the ports for exactly one
// cycle with valid_o high; the receiver cannot stall, so results must be taken
// as they come. last_o marks the final result of a request.

module binary_search_with_probe_trace #(
  parameter int unsigned TABLE_DEPTH = bsp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [bsp_pkg::REQ_W-1:0]           req_type_i,
  input  logic signed [bsp_pkg::VALUE_W-1:0]  value_i,
  output logic                                busy_o,
  output logic                                valid_o,
  output logic signed [bsp_pkg::VALUE_W-1:0]  probe_value_o,
  output logic                                probe_valid_o,
  output logic                                found_o,
  output logic signed [bsp_pkg::INDEX_W-1:0]  found_index_o,
  output logic                                last_o,
  output logic                                order_error_o,
  output logic                                full_error_o
);

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_APPEND = 3'b010,
    S_SEARCH = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi1_q, hi1_d;
  logic [CNT_W-1:0] mid_q, mid_d;
  logic signed [bsp_pkg::VALUE_W-1:0] key_q, key_d;

  // Result registers
  logic                                valid_q, valid_d;
  logic signed [bsp_pkg::VALUE_W-1:0]  pval_q, pval_d;
  logic                                pvalid_q, pvalid_d;
  logic                                found_q, found_d;
  logic signed [bsp_pkg::INDEX_W-1:0]  idx_q, idx_d;
  logic                                last_q, last_d;
  logic                                oerr_q, oerr_d;
  logic                                ferr_q, ferr_d;

  // Table RAM ports
  logic signed [bsp_pkg::VALUE_W-1:0] table_mem [TABLE_DEPTH];
  logic signed [bsp_pkg::VALUE_W-1:0] rdata_q;
  logic                               rd_en;
  logic [ADDR_W-1:0]                  rd_addr;
  logic                               wr_en;
  logic [ADDR_W-1:0]                  wr_addr;

  // Probe step
  logic [CNT_W-1:0]     lo_nxt, hi1_nxt, mid_nxt;
  bsp_pkg::probe_stat_t stat;
  logic [CNT_W-1:0]     count_m1;
  logic [31:0]          mid_wide;

  bsp_probe #(
    .CNT_W (CNT_W)
  ) u_probe (
    .lo_i    (lo_q),
    .hi1_i   (hi1_q),
    .mid_i   (mid_q),
    .probe_i (rdata_q),
    .key_i   (key_q),
    .lo_o    (lo_nxt),
    .hi1_o   (hi1_nxt),
    .mid_o   (mid_nxt),
    .stat_o  (stat)
  );

  assign count_m1 = count_q - CNT_W'(1);
  assign mid_wide = 32'(mid_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    lo_d    = lo_q;
    hi1_d   = hi1_q;
    mid_d   = mid_q;
    key_d   = key_q;

    rd_en   = 1'b0;
    rd_addr = mid_q[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = count_q[ADDR_W-1:0];

    // Default result: a single non-probe transfer
    valid_d  = 1'b0;
    pval_d   = '0;
    pvalid_d = 1'b0;
    found_d  = 1'b0;
    idx_d    = bsp_pkg::NOT_FOUND;
    last_d   = 1'b1;
    oerr_d   = 1'b0;
    ferr_d   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d = value_i;
          case (req_type_i)
            bsp_pkg::REQ_APPEND: begin
              if (count_q >= CNT_W'(TABLE_DEPTH)) begin
                valid_d = 1'b1;
                ferr_d  = 1'b1;
              end else if (count_q == '0) begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
                valid_d = 1'b1;
              end else begin
                // Fetch the last entry for the order check
                rd_en   = 1'b1;
                rd_addr = count_m1[ADDR_W-1:0];
                state_d = S_APPEND;
              end
            end
            bsp_pkg::REQ_SEARCH: begin
              if (count_q == '0) begin
                valid_d = 1'b1;
              end else begin
                lo_d    = '0;
                hi1_d   = count_q;
                mid_d   = count_m1 >> 1;
                rd_en   = 1'b1;
                rd_addr = mid_d[ADDR_W-1:0];
                state_d = S_SEARCH;
              end
            end
            bsp_pkg::REQ_CLEAR: begin
              count_d = '0;
              valid_d = 1'b1;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      S_APPEND: begin
        valid_d = 1'b1;
        if (key_q < rdata_q) begin
          oerr_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end

      S_SEARCH: begin
        // Report this probe and launch the next read in the same cycle
        valid_d  = 1'b1;
        pval_d   = rdata_q;
        pvalid_d = 1'b1;
        found_d  = stat.hit;
        idx_d    = stat.hit ? mid_wide[bsp_pkg::INDEX_W-1:0] : bsp_pkg::NOT_FOUND;
        last_d   = stat.done;
        lo_d     = lo_nxt;
        hi1_d    = hi1_nxt;
        mid_d    = mid_nxt;
        if (stat.done) begin
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = mid_nxt[ADDR_W-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Table RAM with registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= key_d;
    end
    if (rd_en) begin
      rdata_q <= table_mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Search window and result payload
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi1_q    <= hi1_d;
    mid_q    <= mid_d;
    key_q    <= key_d;
    pval_q   <= pval_d;
    pvalid_q <= pvalid_d;
    found_q  <= found_d;
    idx_q    <= idx_d;
    last_q   <= last_d;
    oerr_q   <= oerr_d;
    ferr_q   <= ferr_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign probe_value_o = pval_q;
  assign probe_valid_o = pvalid_q;
  assign found_o       = found_q;
  assign found_index_o = idx_q;
  assign last_o        = last_q;
  assign order_error_o = oerr_q;
  assign full_error_o  = ferr_q;

endmodule

### sv/bsp_probe.sv
// bsp_probe: one step of the binary search - compares the probed entry with the
// key, narrows the bounds and forms the next midpoint. Depends on bsp_pkg.
`timescale 1ns / 1ps

module bsp_probe #(
  parameter int unsigned CNT_W = 11
) (
  input  logic [CNT_W-1:0]                  lo_i,    // low bound, inclusive
  input  logic [CNT_W-1:0]                  hi1_i,   // high bound plus one
  input  logic [CNT_W-1:0]                  mid_i,   // index just probed
  input  logic signed [bsp_pkg::VALUE_W-1:0] probe_i, // entry read at mid_i
  input  logic signed [bsp_pkg::VALUE_W-1:0] key_i,
  output logic [CNT_W-1:0]                  lo_o,
  output logic [CNT_W-1:0]                  hi1_o,
  output logic [CNT_W-1:0]                  mid_o,
  output bsp_pkg::probe_stat_t              stat_o
);

  logic hit;
  logic greater;

  assign hit     = (probe_i == key_i);
  assign greater = (probe_i > key_i);

  // Narrow the window around the probe
  always_comb begin
    lo_o  = lo_i;
    hi1_o = hi1_i;
    if (greater) begin
      hi1_o = mid_i;
    end else if (!hit) begin
      lo_o = mid_i + CNT_W'(1);
    end
  end

  // Next midpoint; only meaningful while the window is not empty
  assign mid_o = lo_o + ((hi1_o - lo_o - CNT_W'(1)) >> 1);

  assign stat_o.hit  = hit;
  assign stat_o.done = hit || (lo_o >= hi1_o);

endmodule
